/* rtl/xenc_pkg.sv */
// Package: payload types, instruction form codes and the byte template encoder.
`default_nettype none
package xenc_pkg;

   localparam int MaxBytes = 12;

   typedef enum logic [5:0] {
      K_RAW8, K_RAW16, K_RAW32, K_RAW64, K_PUSH, K_POP, K_RET,
      K_MOV_RR, K_MOV_RI64, K_MOV_LOAD, K_MOV_STORE, K_LEA,
      K_ADD_RR, K_ADD_RI, K_SUB_RI, K_IMUL_RR, K_CMP_RR, K_CMP_RI, K_XOR_RR, K_INC,
      K_CALL_ABS, K_JMP_FWD, K_JL_FWD, K_JGE_FWD, K_JMP_BACK, K_JL_BACK, K_JGE_BACK,
      K_MOVUPS_LD, K_MOVUPS_ST, K_MOVAPS_LD, K_MOVAPS_ST,
      K_ADDPS, K_MULPS, K_XORPS, K_MAXPS, K_SHUFPS,
      K_MOVSS_LD, K_MOVSS_ST, K_MOVAPS_RR, K_ADDSS, K_MULSS, K_MAXSS, K_ADDSS_MEM,
      K_SHL_RI, K_IMUL_RRI, K_CLEAR
   } kind_type;

   localparam logic [7:0] RexBase  = 8'h40;
   localparam logic [7:0] SibRsp   = 8'h24;
   localparam logic [7:0] OpJmp    = 8'hE9;
   localparam logic [7:0] OpJl     = 8'h8C;
   localparam logic [7:0] OpJge    = 8'h8D;
   localparam logic [7:0] PfxF3    = 8'hF3;
   localparam logic [7:0] OpEsc    = 8'h0F;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  dst_reg;
      logic [3:0]  src_reg;
      logic [31:0] disp;
      logic [63:0] immediate;
      logic [19:0] target;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic [20:0] byte_offset;
      logic        stored;
      logic [20:0] fixup_pos;
      logic        last;
   } rsp_type;

   // one instruction as a byte template for the back end
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] code;
      logic [3:0]  len;
      logic [1:0]  op_len;
      logic        fwd;
      logic        back;
      logic        clr;
      logic [19:0] target;
   } enc_type;

   function automatic enc_type put8(enc_type e, logic [7:0] v);
      enc_type r;
      r = e;
      if (r.len < 4'(MaxBytes)) begin
         r.code[r.len] = v;
         r.len = r.len + 4'd1;
      end
      return r;
   endfunction

   function automatic enc_type put32(enc_type e, logic [31:0] v);
      enc_type r;
      r = put8(e, v[7:0]);
      r = put8(r, v[15:8]);
      r = put8(r, v[23:16]);
      r = put8(r, v[31:24]);
      return r;
   endfunction

   function automatic logic fits8(logic [31:0] v);
      return (v[31:7] == '0) || (v[31:7] == '1);
   endfunction

   function automatic logic [7:0] modrm(logic [1:0] md, logic [3:0] reg_n, logic [3:0] rm);
      return {md, reg_n[2:0], rm[2:0]};
   endfunction

   function automatic logic [7:0] rexw(logic [3:0] reg_n, logic [3:0] rm);
      return RexBase | 8'h08 | {5'b0, reg_n[3], 1'b0, rm[3]};
   endfunction

   function automatic enc_type mem_op(enc_type e, logic [3:0] reg_n, logic [3:0] base,
                                      logic [31:0] d);
      enc_type r;
      logic [1:0] md;
      if (d == '0 && base[2:0] != 3'd5) md = 2'd0;
      else if (fits8(d)) md = 2'd1;
      else md = 2'd2;
      r = put8(e, modrm(md, reg_n, base));
      if (base[2:0] == 3'd4) r = put8(r, SibRsp);
      if (md == 2'd1) r = put8(r, d[7:0]);
      else if (md == 2'd2) r = put32(r, d);
      return r;
   endfunction

   function automatic enc_type sse(enc_type e, logic [7:0] op, logic [3:0] dx, logic [3:0] sb,
                                   logic mem, logic [31:0] d);
      enc_type r;
      r = e;
      if (dx[3] || sb[3]) r = put8(r, RexBase | {5'b0, dx[3], 1'b0, sb[3]});
      r = put8(r, OpEsc);
      r = put8(r, op);
      if (mem) r = mem_op(r, dx, sb, d);
      else r = put8(r, modrm(2'd3, dx, sb));
      return r;
   endfunction

   function automatic enc_type arith_imm(enc_type e, logic [3:0] ext, logic [3:0] rg,
                                         logic [31:0] imm);
      enc_type r;
      r = put8(e, rexw(4'd0, rg));
      if (fits8(imm)) begin
         r = put8(r, 8'h83);
         r = put8(r, modrm(2'd3, ext, rg));
         r = put8(r, imm[7:0]);
      end else begin
         r = put8(r, 8'h81);
         r = put8(r, modrm(2'd3, ext, rg));
         r = put32(r, imm);
      end
      return r;
   endfunction

   function automatic enc_type rr(enc_type e, logic [7:0] op, logic [3:0] reg_n,
                                  logic [3:0] rm);
      enc_type r;
      r = put8(e, rexw(reg_n, rm));
      r = put8(r, op);
      r = put8(r, modrm(2'd3, reg_n, rm));
      return r;
   endfunction

   // full byte template of one request; len stays zero for unused codes
   function automatic enc_type encode(req_type q);
      enc_type e;
      logic [3:0]  dr;
      logic [3:0]  sr;
      logic [31:0] d;
      logic [31:0] i32;
      e = '0;
      dr = q.dst_reg;
      sr = q.src_reg;
      d = q.disp;
      i32 = q.immediate[31:0];
      e.target = q.target;
      case (q.kind)
         K_RAW8:  e = put8(e, i32[7:0]);
         K_RAW16: begin
            e = put8(e, i32[7:0]);
            e = put8(e, i32[15:8]);
         end
         K_RAW32: e = put32(e, i32);
         K_RAW64: begin
            e = put32(e, i32);
            e = put32(e, q.immediate[63:32]);
         end
         K_PUSH: begin
            if (dr[3]) e = put8(e, 8'h41);
            e = put8(e, 8'h50 + {5'b0, dr[2:0]});
         end
         K_POP: begin
            if (dr[3]) e = put8(e, 8'h41);
            e = put8(e, 8'h58 + {5'b0, dr[2:0]});
         end
         K_RET:    e = put8(e, 8'hC3);
         K_MOV_RR: e = rr(e, 8'h89, sr, dr);
         K_MOV_RI64: begin
            e = put8(e, RexBase | 8'h08 | {7'b0, dr[3]});
            e = put8(e, 8'hB8 + {5'b0, dr[2:0]});
            e = put32(e, i32);
            e = put32(e, q.immediate[63:32]);
         end
         K_MOV_LOAD, K_MOV_STORE, K_LEA: begin
            e = put8(e, rexw(dr, sr));
            if (q.kind == K_MOV_LOAD) e = put8(e, 8'h8B);
            else if (q.kind == K_MOV_STORE) e = put8(e, 8'h89);
            else e = put8(e, 8'h8D);
            e = mem_op(e, dr, sr, d);
         end
         K_ADD_RR: e = rr(e, 8'h01, sr, dr);
         K_ADD_RI: e = arith_imm(e, 4'd0, dr, i32);
         K_SUB_RI: e = arith_imm(e, 4'd5, dr, i32);
         K_IMUL_RR: begin
            e = put8(e, rexw(dr, sr));
            e = put8(e, OpEsc);
            e = put8(e, 8'hAF);
            e = put8(e, modrm(2'd3, dr, sr));
         end
         K_CMP_RR: e = rr(e, 8'h39, sr, dr);
         K_CMP_RI: e = arith_imm(e, 4'd7, dr, i32);
         K_XOR_RR: e = rr(e, 8'h31, sr, dr);
         K_INC: begin
            e = put8(e, rexw(4'd0, dr));
            e = put8(e, 8'hFF);
            e = put8(e, modrm(2'd3, 4'd0, dr));
         end
         K_CALL_ABS: begin
            e = put8(e, RexBase | 8'h08);
            e = put8(e, 8'hB8);
            e = put32(e, i32);
            e = put32(e, q.immediate[63:32]);
            e = put8(e, 8'hFF);
            e = put8(e, modrm(2'd3, 4'd2, 4'd0));
         end
         K_JMP_FWD, K_JMP_BACK: begin
            e = put8(e, OpJmp);
            e.op_len = 2'd1;
            e = put32(e, 32'd0);
            e.fwd = (q.kind == K_JMP_FWD);
            e.back = (q.kind == K_JMP_BACK);
         end
         K_JL_FWD, K_JGE_FWD, K_JL_BACK, K_JGE_BACK: begin
            e = put8(e, OpEsc);
            e = put8(e, (q.kind == K_JL_FWD || q.kind == K_JL_BACK) ? OpJl : OpJge);
            e.op_len = 2'd2;
            e = put32(e, 32'd0);
            e.fwd = (q.kind == K_JL_FWD || q.kind == K_JGE_FWD);
            e.back = !e.fwd;
         end
         K_MOVUPS_LD: e = sse(e, 8'h10, dr, sr, 1'b1, d);
         K_MOVUPS_ST: e = sse(e, 8'h11, dr, sr, 1'b1, d);
         K_MOVAPS_LD: e = sse(e, 8'h28, dr, sr, 1'b1, d);
         K_MOVAPS_ST: e = sse(e, 8'h29, dr, sr, 1'b1, d);
         K_ADDPS:     e = sse(e, 8'h58, dr, sr, 1'b0, 32'd0);
         K_MULPS:     e = sse(e, 8'h59, dr, sr, 1'b0, 32'd0);
         K_XORPS:     e = sse(e, 8'h57, dr, sr, 1'b0, 32'd0);
         K_MAXPS:     e = sse(e, 8'h5F, dr, sr, 1'b0, 32'd0);
         K_SHUFPS: begin
            e = sse(e, 8'hC6, dr, sr, 1'b0, 32'd0);
            e = put8(e, i32[7:0]);
         end
         K_MOVSS_LD:  e = sse(put8(e, PfxF3), 8'h10, dr, sr, 1'b1, d);
         K_MOVSS_ST:  e = sse(put8(e, PfxF3), 8'h11, dr, sr, 1'b1, d);
         K_MOVAPS_RR: e = sse(e, 8'h28, dr, sr, 1'b0, 32'd0);
         K_ADDSS:     e = sse(put8(e, PfxF3), 8'h58, dr, sr, 1'b0, 32'd0);
         K_MULSS:     e = sse(put8(e, PfxF3), 8'h59, dr, sr, 1'b0, 32'd0);
         K_MAXSS:     e = sse(put8(e, PfxF3), 8'h5F, dr, sr, 1'b0, 32'd0);
         K_ADDSS_MEM: e = sse(put8(e, PfxF3), 8'h58, dr, sr, 1'b1, d);
         K_SHL_RI: begin
            e = put8(e, rexw(4'd0, dr));
            e = put8(e, 8'hC1);
            e = put8(e, modrm(2'd3, 4'd4, dr));
            e = put8(e, i32[7:0]);
         end
         K_IMUL_RRI: begin
            e = put8(e, rexw(dr, sr));
            e = put8(e, 8'h69);
            e = put8(e, modrm(2'd3, dr, sr));
            e = put32(e, i32);
         end
         K_CLEAR: e.clr = 1'b1;
         default: e.len = 4'd0;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

/* rtl/xenc_front.sv */
// Front end: accepts requests, builds the byte template, pushes it to the queue.
`default_nettype none
module xenc_front (
   input  wire logic             req_valid,
   input  wire xenc_pkg::req_type req_payload,
   output logic                  req_stall,
   input  wire logic             q_full,
   output logic                  q_push,
   output xenc_pkg::enc_type     q_data
);

   logic accept;

   // stall only on a full queue
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_data    = xenc_pkg::encode(req_payload);
   // unused codes are dropped here
   assign q_push    = accept && (q_data.clr || q_data.len != 4'd0);

endmodule
`default_nettype wire

/* rtl/xenc_queue.sv */
// Two-entry queue of byte templates between front and back end.
`default_nettype none
module xenc_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire xenc_pkg::enc_type wr_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output xenc_pkg::enc_type  rd_data
);

   xenc_pkg::enc_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/xenc_back.sv */
// Back end: holds the byte count, resolves jump fields, emits one byte a cycle unless stalled.
`default_nettype none
module xenc_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [20:0]   cap_eff,
   input  wire logic          q_empty,
   input  wire xenc_pkg::enc_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output xenc_pkg::rsp_type  rsp_payload
);

   xenc_pkg::enc_type cur_ff, cur_in;
   logic              cur_vld_ff, cur_vld_in;
   logic [3:0]        idx_ff, idx_in;
   logic [20:0]       patch_ff, patch_in;
   logic [20:0]       count_ff, count_in;
   logic              out_vld_ff, out_vld_in;
   xenc_pkg::rsp_type out_ff, out_in;

   logic        emit;
   logic        ok;
   logic        is_last;
   logic [20:0] room;
   logic [1:0]  op_stored;
   logic [20:0] pc;
   logic [31:0] rel;

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;
   assign q_pop       = !cur_vld_ff && !q_empty;

   // count after the opcode bytes, assuming the queue head loads now
   always_comb begin
      room      = (cap_eff > count_ff) ? (cap_eff - count_ff) : 21'd0;
      op_stored = (room >= {19'd0, q_data.op_len}) ? q_data.op_len : room[1:0];
      pc        = count_ff + {19'd0, op_stored};
      rel       = {12'd0, q_data.target} - ({11'd0, pc} + 32'd4);
   end

   assign emit    = cur_vld_ff && (!out_vld_ff || !rsp_stall);
   assign ok      = count_ff < cap_eff;
   assign is_last = (idx_ff == cur_ff.len - 4'd1);

   always_comb begin
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      idx_in     = idx_ff;
      patch_in   = patch_ff;
      count_in   = count_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      out_in     = out_ff;
      if (q_pop) begin
         // load the next template, or clear the count
         if (q_data.clr) begin
            count_in = 21'd0;
         end else begin
            cur_in     = q_data;
            cur_vld_in = 1'b1;
            idx_in     = 4'd0;
            patch_in   = q_data.fwd ? pc : 21'd0;
            if (q_data.back) begin
               for (int i = 0; i < 4; i++) begin
                  cur_in.code[4'(i) + {2'b0, q_data.op_len}] = rel[8*i +: 8];
               end
            end
         end
      end else if (emit) begin
         out_in.code_byte   = cur_ff.code[idx_ff];
         out_in.byte_offset = count_ff;
         out_in.stored      = ok;
         out_in.fixup_pos   = patch_ff;
         out_in.last        = is_last;
         out_vld_in         = 1'b1;
         if (ok) count_in = count_ff + 21'd1;
         idx_in = idx_ff + 4'd1;
         if (is_last) cur_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         count_ff   <= 21'd0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      patch_ff <= patch_in;
      out_ff   <= out_in;
   end

endmodule
`default_nettype wire

/* rtl/x86_64_instruction_encoder.sv */
// Top level of the x86-64 instruction encoder.
//
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    xenc_pkg::req_type
//  rsp      out  rsp_valid/stall    xenc_pkg::rsp_type, one code byte each
//  csr      in   csr_valid/ready    capacity, 21 bits
//
// In the back end an instruction first loads its template and resolves jump
// offsets against the byte count, then sends one byte per cycle while the
// response is not stalled. The front end takes a request every cycle while
// the two-entry queue has room. Reset is synchronous, clears the count and
// sets capacity to 4096. A stalled response holds its register.
`default_nettype none
module x86_64_instruction_encoder #(
   parameter int MAX_BUFFER_BYTES = 1048576
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire xenc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output xenc_pkg::rsp_type  rsp_payload,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [20:0]   csr_data
);

   logic [20:0]       cap_ff, cap_in;
   logic [20:0]       cap_eff;
   logic              q_full, q_push, q_pop, q_empty;
   xenc_pkg::enc_type q_wdata, q_rdata;

   // capacity register
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;
   assign cap_eff   = (32'(cap_ff) > 32'(MAX_BUFFER_BYTES)) ? 21'(MAX_BUFFER_BYTES) : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 21'd4096;
      end else begin
         cap_ff <= cap_in;
      end
   end

   xenc_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   xenc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rdata)
   );

   xenc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cap_eff     (cap_eff),
      .q_empty     (q_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* rtl/xenc_checker.sv */
// Port-level checker for the encoder, bound to the top level.
`default_nettype none
module xenc_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_valid,
   input wire logic          rsp_stall,
   input wire xenc_pkg::rsp_type rsp_payload
);

   logic rsp_acc;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");

   // bytes of one instruction come without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside an instruction");

   // a stored byte advances the offset by one
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_payload.last && rsp_payload.stored |=>
      rsp_payload.byte_offset == $past(rsp_payload.byte_offset) + 21'd1)
      else $error("offset did not advance");

   // fixup position is the same on every byte of an instruction
   a_patch: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_payload.last |=>
      rsp_payload.fixup_pos == $past(rsp_payload.fixup_pos))
      else $error("fixup position changed inside an instruction");

endmodule

bind x86_64_instruction_encoder xenc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
